// File: hdl/bpc_pkg.sv
// shared types and constants of the barometric pressure compensation core
`default_nettype none

package bpc_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } bpc_reg_t;

    localparam int TEMP_REF    = 2000;    // 20.00 C
    localparam int COLD_SHIFT  = 3500;    // distance from 20 C down to -15 C
    localparam int TEMP_MIN    = -4000;
    localparam int TEMP_MAX    = 8500;
    localparam int PRESS_MIN   = 1000;
    localparam int PRESS_MAX   = 120000;
    localparam int TRUNC_BIAS  = 8388607; // 2^23 - 1, rounds toward zero

    typedef struct packed {
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] c3;
        logic [15:0] c4;
        logic [15:0] c5;
        logic [15:0] c6;
    } bpc_calib_t;

    // first-order terms
    typedef struct packed {
        logic [23:0]        d1;
        logic signed [17:0] q;      // dT*C6/2^23, first-order temp minus 2000
        logic [16:0]        t2;     // dT^2/2^31
        logic signed [34:0] off;
        logic signed [33:0] sens;
    } bpc_first_t;

    // second-order corrected terms
    typedef struct packed {
        logic [23:0]        d1;
        logic signed [19:0] temp;
        logic signed [39:0] off;
        logic signed [39:0] sens;
    } bpc_final_t;

    // unclamped results
    typedef struct packed {
        logic signed [19:0] temp;
        logic signed [28:0] press;
    } bpc_result_t;

endpackage

`default_nettype wire

// File: hdl/barometric_pressure_compensation_core.sv
// top level: calibration registers, compensation pipeline and saturating output stage
`default_nettype none

// Barometer compensation core. Each input beat carries one raw temperature
// conversion (D2) and one raw pressure conversion (D1); each output beat carries
// the compensated temperature in 0.01 C, the pressure in pascals, both clamped
// to the sensor range, and a flag in tuser that is set when either was clamped.
// The six calibration words C1..C6 are written through the cfg port at indexes
// 0..5 (other indexes are ignored) and must only change while no beat is in
// flight. The datapath is a nine-stage pipeline: three first-order stages, two
// second-order correction stages, three pressure stages and the output register.
// Throughput is one beat per cycle unless m_tready stalls; every stage has its
// own valid bit and ready term, so m_tready back-pressure ripples back to
// s_tready and empty stages keep absorbing beats during a stall. The widest
// unit is the D1*SENS product, built from two 24x20 partial products.
module barometric_pressure_compensation_core import bpc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [23:0] raw_temperature, [47:24] raw_pressure
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [14:0] temperature_centi, [31:15] pressure_pascal
    output logic             m_tuser    // [0] saturated
);

    bpc_calib_t calib_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calib_reg <= '0;
        end else if (cfg_we) begin
            case (bpc_reg_t'(cfg_addr))
                REG_C1:  calib_reg.c1 <= cfg_wdata;
                REG_C2:  calib_reg.c2 <= cfg_wdata;
                REG_C3:  calib_reg.c3 <= cfg_wdata;
                REG_C4:  calib_reg.c4 <= cfg_wdata;
                REG_C5:  calib_reg.c5 <= cfg_wdata;
                REG_C6:  calib_reg.c6 <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic        first_valid, first_ready;
    bpc_first_t  first_data;
    logic        final_valid, final_ready;
    bpc_final_t  final_data;
    logic        res_valid, res_ready;
    bpc_result_t res_data;

    bpc_temp u_temp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .calib           (calib_reg),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .raw_temperature (s_tdata[23:0]),
        .raw_pressure    (s_tdata[47:24]),
        .out_valid       (first_valid),
        .out_ready       (first_ready),
        .out_data        (first_data)
    );

    bpc_corr u_corr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (first_valid),
        .in_ready  (first_ready),
        .in_data   (first_data),
        .out_valid (final_valid),
        .out_ready (final_ready),
        .out_data  (final_data)
    );

    bpc_press u_press (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (final_valid),
        .in_ready  (final_ready),
        .in_data   (final_data),
        .out_valid (res_valid),
        .out_ready (res_ready),
        .out_data  (res_data)
    );

    // output stage: clamp to sensor range
    logic        m_valid_reg;
    logic [14:0] temp_next, temp_reg;
    logic [16:0] press_next, press_reg;
    logic        sat_next, sat_reg;

    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        sat_next  = 1'b0;
        temp_next = res_data.temp[14:0];
        if (res_data.temp < TEMP_MIN) begin
            temp_next = 15'(TEMP_MIN);
            sat_next  = 1'b1;
        end else if (res_data.temp > TEMP_MAX) begin
            temp_next = 15'(TEMP_MAX);
            sat_next  = 1'b1;
        end
        press_next = res_data.press[16:0];
        if (res_data.press < PRESS_MIN) begin
            press_next = 17'(PRESS_MIN);
            sat_next   = 1'b1;
        end else if (res_data.press > PRESS_MAX) begin
            press_next = 17'(PRESS_MAX);
            sat_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready) begin
            temp_reg  <= temp_next;
            press_reg <= press_next;
            sat_reg   <= sat_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {press_reg, temp_reg};
    assign m_tuser  = sat_reg;

    // an empty output register means every stage can take a beat
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled while output register is empty");

    a_result_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ($signed(temp_reg) >= 15'(TEMP_MIN))
                     && ($signed(temp_reg) <= 15'(TEMP_MAX))
                     && (press_reg >= 17'(PRESS_MIN))
                     && (press_reg <= 17'(PRESS_MAX)))
        else $error("result outside sensor range");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

// File: hdl/bpc_temp.sv
// first-order stages: dT, coefficient products, first-order temperature, offset, sensitivity
`default_nettype none

module bpc_temp import bpc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire bpc_calib_t  calib,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [23:0] raw_temperature,
    input  wire logic [23:0] raw_pressure,
    output logic             out_valid,
    input  wire logic        out_ready,
    output bpc_first_t       out_data
);

    localparam int NS = 3;

    logic [NS-1:0] valid_reg;
    logic [NS:0]   stage_ready;

    always_comb begin
        stage_ready[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_ready[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // stage 1: dT
    logic signed [24:0] dt_next, dt_reg;
    logic [23:0]        d1_s1_reg;

    assign dt_next = {1'b0, raw_temperature} - {1'b0, calib.c5, 8'h00};

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            dt_reg    <= dt_next;
            d1_s1_reg <= raw_pressure;
        end
    end

    // stage 2: products of dT
    logic signed [40:0] dt_w, c6_w, c4_w, c3_w;
    logic signed [49:0] dt_sq_w, dt_sq;
    logic signed [40:0] p6_next, p4_next, p3_next;
    logic signed [40:0] p6_reg, p4_reg, p3_reg;
    logic [16:0]        t2_next, t2_reg;
    logic [23:0]        d1_s2_reg;

    assign dt_w    = {{16{dt_reg[24]}}, dt_reg};
    assign c6_w    = $signed({25'b0, calib.c6});
    assign c4_w    = $signed({25'b0, calib.c4});
    assign c3_w    = $signed({25'b0, calib.c3});
    assign dt_sq_w = {{25{dt_reg[24]}}, dt_reg};
    assign p6_next = dt_w * c6_w;
    assign p4_next = dt_w * c4_w;
    assign p3_next = dt_w * c3_w;
    assign dt_sq   = dt_sq_w * dt_sq_w;
    assign t2_next = dt_sq[47:31];

    always_ff @(posedge aclk) begin
        if (stage_ready[1]) begin
            p6_reg    <= p6_next;
            p4_reg    <= p4_next;
            p3_reg    <= p3_next;
            t2_reg    <= t2_next;
            d1_s2_reg <= d1_s1_reg;
        end
    end

    // stage 3: first-order temperature, offset and sensitivity
    logic signed [40:0] p6_adj;
    bpc_first_t         first_next, first_reg;

    always_comb begin
        // truncate toward zero on negative products
        if (p6_reg < 0) begin
            p6_adj = p6_reg + 41'(TRUNC_BIAS);
        end else begin
            p6_adj = p6_reg;
        end
        first_next.d1   = d1_s2_reg;
        first_next.q    = $signed(p6_adj[40:23]);
        first_next.t2   = t2_reg;
        first_next.off  = {3'b000, calib.c2, 16'h0000} + {p4_reg[40], p4_reg[40:7]};
        first_next.sens = {3'b000, calib.c1, 15'h0000} + {p3_reg[40], p3_reg[40:8]};
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[2]) begin
            first_reg <= first_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NS-1];
    assign out_data  = first_reg;

endmodule

`default_nettype wire

// File: hdl/bpc_corr.sv
// second-order correction stages: squares, T2/OFF2/SENS2 and corrected terms
`default_nettype none

module bpc_corr import bpc_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire bpc_first_t in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output bpc_final_t      out_data
);

    localparam int NS = 2;

    logic [NS-1:0] valid_reg;
    logic [NS:0]   stage_ready;

    always_comb begin
        stage_ready[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_ready[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // stage 4: squares of the distance below 20 C and below -15 C
    logic signed [35:0] q_w, a_sq;
    logic signed [18:0] temp1_next, b_next;
    logic signed [37:0] b_w, b_sq;
    logic [34:0]        a2_next, a2_reg, b2_next, b2_reg;
    logic               warm_lo_reg, cold_lo_reg;
    logic signed [18:0] temp1_reg;
    logic [16:0]        t2_reg;
    logic signed [34:0] off1_reg;
    logic signed [33:0] sens1_reg;
    logic [23:0]        d1_s4_reg;

    assign q_w        = {{18{in_data.q[17]}}, in_data.q};
    assign a_sq       = q_w * q_w;
    assign a2_next    = a_sq[34:0];
    assign temp1_next = {in_data.q[17], in_data.q} + 19'(TEMP_REF);
    assign b_next     = {in_data.q[17], in_data.q} + 19'(COLD_SHIFT);
    assign b_w        = {{19{b_next[18]}}, b_next};
    assign b_sq       = b_w * b_w;
    assign b2_next    = b_sq[34:0];

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            a2_reg      <= a2_next;
            b2_reg      <= b2_next;
            warm_lo_reg <= in_data.q[17];   // below 20 C
            cold_lo_reg <= b_next[18];      // below -15 C
            temp1_reg   <= temp1_next;
            t2_reg      <= in_data.t2;
            off1_reg    <= in_data.off;
            sens1_reg   <= in_data.sens;
            d1_s4_reg   <= in_data.d1;
        end
    end

    // stage 5: corrections applied
    logic [36:0] a5;
    logic [37:0] b7, b11;
    logic [37:0] off2, sens2;
    bpc_final_t  final_next, final_reg;

    always_comb begin
        a5  = {2'b00, a2_reg} + {a2_reg, 2'b00};
        b7  = {b2_reg, 3'b000} - {3'b000, b2_reg};
        b11 = {b2_reg, 3'b000} + {2'b00, b2_reg, 1'b0} + {3'b000, b2_reg};
        off2  = '0;
        sens2 = '0;
        if (warm_lo_reg) begin
            off2  = {1'b0, a5[36:1]};
            sens2 = {3'b000, a5[36:2]};
            if (cold_lo_reg) begin
                off2  = {1'b0, a5[36:1]} + b7;
                sens2 = {3'b000, a5[36:2]} + {1'b0, b11[37:1]};
            end
        end
        final_next.d1   = d1_s4_reg;
        final_next.temp = {temp1_reg[18], temp1_reg}
                        - (warm_lo_reg ? {3'b000, t2_reg} : 20'd0);
        final_next.off  = {{5{off1_reg[34]}}, off1_reg} - {2'b00, off2};
        final_next.sens = {{6{sens1_reg[33]}}, sens1_reg} - {2'b00, sens2};
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[1]) begin
            final_reg <= final_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NS-1];
    assign out_data  = final_reg;

endmodule

`default_nettype wire

// File: hdl/bpc_press.sv
// pressure stages: split D1*SENS product, recombine, subtract offset and scale
`default_nettype none

module bpc_press import bpc_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire bpc_final_t in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output bpc_result_t     out_data
);

    localparam int NS = 3;

    logic [NS-1:0] valid_reg;
    logic [NS:0]   stage_ready;

    always_comb begin
        stage_ready[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_ready[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // stage 6: partial products on the low 20 and high 20 bits of SENS
    logic [43:0]        d1_u, lo_u, pp_lo_next, pp_lo_reg;
    logic signed [43:0] d1_s, hi_s, pp_hi_next, pp_hi_reg;
    logic signed [39:0] off_s6_reg, off_s7_reg;
    logic signed [19:0] temp_s6_reg, temp_s7_reg;

    assign d1_u       = {20'b0, in_data.d1};
    assign lo_u       = {24'b0, in_data.sens[19:0]};
    assign pp_lo_next = d1_u * lo_u;
    assign d1_s       = $signed({20'b0, in_data.d1});
    assign hi_s       = {{24{in_data.sens[39]}}, in_data.sens[39:20]};
    assign pp_hi_next = d1_s * hi_s;

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            pp_lo_reg   <= pp_lo_next;
            pp_hi_reg   <= pp_hi_next;
            off_s6_reg  <= in_data.off;
            temp_s6_reg <= in_data.temp;
        end
    end

    // stage 7: full product, floor by 2^21
    logic signed [63:0] prod;
    logic signed [42:0] scaled_next, scaled_reg;

    assign prod        = {pp_hi_reg, 20'h00000} + {20'h00000, pp_lo_reg};
    assign scaled_next = prod[63:21];

    always_ff @(posedge aclk) begin
        if (stage_ready[1]) begin
            scaled_reg  <= scaled_next;
            off_s7_reg  <= off_s6_reg;
            temp_s7_reg <= temp_s6_reg;
        end
    end

    // stage 8: subtract offset, floor by 2^15
    logic signed [43:0] diff;
    bpc_result_t        result_next, result_reg;

    always_comb begin
        diff              = {scaled_reg[42], scaled_reg} - {{4{off_s7_reg[39]}}, off_s7_reg};
        result_next.press = diff[43:15];
        result_next.temp  = temp_s7_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[2]) begin
            result_reg <= result_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NS-1];
    assign out_data  = result_reg;

endmodule

`default_nettype wire

// File: sim/barometric_pressure_compensation_core_tb.sv
// self-checking testbench of the barometric pressure compensation core
`default_nettype none

module barometric_pressure_compensation_core_tb;
    import bpc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 120;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_PHASES = 9;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int MAX_PRINTS = 100;
    localparam logic [23:0] RAW_MAX = 24'hFFFFFF;
    localparam longint TEMP_DIV = longint'(TRUNC_BIAS) + 1;  // 2^23

    // indexes past the last calibration word, writes there must be dropped
    localparam logic [2:0] ADDR_SPARE_LO = 3'd6;
    localparam logic [2:0] ADDR_SPARE_HI = 3'd7;

    localparam bpc_calib_t CAL_TYPICAL = {16'd40127, 16'd36924, 16'd23317,
                                          16'd23282, 16'd33464, 16'd28312};
    localparam bpc_calib_t CAL_ONES = {6{16'hFFFF}};
    localparam bpc_calib_t CAL_ZERO = '0;

    typedef struct packed {
        logic [23:0]        d2;
        logic [23:0]        d1;
        logic signed [14:0] temp;
        logic [16:0]        press;
        logic               sat;
    } comp_result_t;

    class conversion_scoreboard;
        bpc_calib_t   calib;
        comp_result_t expected_q[$];
        int           errors;

        function new();
            calib = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] addr, logic [15:0] val);
            case (addr)
                REG_C1: calib.c1 = val;
                REG_C2: calib.c2 = val;
                REG_C3: calib.c3 = val;
                REG_C4: calib.c4 = val;
                REG_C5: calib.c5 = val;
                REG_C6: calib.c6 = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function comp_result_t compensate(logic [23:0] d2, logic [23:0] d1);
            longint dt, temp, off, sens, t2, off2, sens2, p, a2, b2;
            logic clamp;
            comp_result_t r;
            clamp = 1'b0;
            t2 = 0;
            off2 = 0;
            sens2 = 0;
            dt = longint'(d2) - longint'(calib.c5) * 256;
            // signed division truncates toward zero
            temp = TEMP_REF + (dt * longint'(calib.c6)) / TEMP_DIV;
            off = longint'(calib.c2) * 65536 + ((longint'(calib.c4) * dt) >>> 7);
            sens = longint'(calib.c1) * 32768 + ((longint'(calib.c3) * dt) >>> 8);
            if (temp < TEMP_REF) begin
                a2 = (temp - TEMP_REF) * (temp - TEMP_REF);
                t2 = (dt * dt) >>> 31;
                off2 = 5 * a2 / 2;
                sens2 = 5 * a2 / 4;
                // extra term below -15 C
                if (temp < TEMP_REF - COLD_SHIFT) begin
                    b2 = (temp - TEMP_REF + COLD_SHIFT) * (temp - TEMP_REF + COLD_SHIFT);
                    off2 += 7 * b2;
                    sens2 += 11 * b2 / 2;
                end
            end
            temp -= t2;
            off -= off2;
            sens -= sens2;
            p = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
            if (temp < TEMP_MIN) begin
                temp = TEMP_MIN;
                clamp = 1'b1;
            end
            if (temp > TEMP_MAX) begin
                temp = TEMP_MAX;
                clamp = 1'b1;
            end
            if (p < PRESS_MIN) begin
                p = PRESS_MIN;
                clamp = 1'b1;
            end
            if (p > PRESS_MAX) begin
                p = PRESS_MAX;
                clamp = 1'b1;
            end
            r.d2 = d2;
            r.d1 = d1;
            r.temp = temp[14:0];
            r.press = p[16:0];
            r.sat = clamp;
            return r;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("mismatch: %s", msg);
        endtask

        task note_conversion(logic [23:0] d2, logic [23:0] d1);
            expected_q.push_back(compensate(d2, d1));
        endtask

        task check_result(logic [31:0] tdata, logic tuser);
            comp_result_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("result beat %h/%b with nothing expected", tdata, tuser));
                return;
            end
            want = expected_q.pop_front();
            if (tdata[14:0] !== want.temp)
                report($sformatf("d2=%h d1=%h temperature_centi got %0d want %0d",
                                 want.d2, want.d1, $signed(tdata[14:0]), want.temp));
            if (tdata[31:15] !== want.press)
                report($sformatf("d2=%h d1=%h pressure_pascal got %0d want %0d",
                                 want.d2, want.d1, tdata[31:15], want.press));
            if (tuser !== want.sat)
                report($sformatf("d2=%h d1=%h saturated got %b want %b",
                                 want.d2, want.d1, tuser, want.sat));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;    // [23:0] raw_temperature, [47:24] raw_pressure
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [14:0] temperature_centi, [31:15] pressure_pascal
    logic        m_tuser;    // [0] saturated

    conversion_scoreboard sb;
    bpc_calib_t cal_now;
    bit steady;
    int results_seen;
    int cycles;

    barometric_pressure_compensation_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(bit no_idle);
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // both handshakes are sampled with the values seen at this edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_conversion(s_tdata[23:0], s_tdata[47:24]);
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tuser);
                results_seen++;
            end
        end
    end

    // result side: random stalls plus a few long hold-offs to back the pipeline up
    initial begin : result_sink
        int gap;
        int next_hold;
        next_hold = 100;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            @(posedge aclk);
            if (results_seen >= next_hold) begin
                next_hold += 250;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                gap = pick_gap(steady);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    task automatic send_conversion(input logic [23:0] d2, input logic [23:0] d1);
        int gap;
        gap = pick_gap(steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata <= 48'({$urandom, $urandom});
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {d1, d2};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [2:0] addr, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= val;
        sb.write_reg(addr, val);
        @(posedge aclk);
    endtask

    task automatic load_calib(input bpc_calib_t c, input bit spare);
        drain_results();
        put_reg(REG_C1, c.c1);
        put_reg(REG_C2, c.c2);
        put_reg(REG_C3, c.c3);
        put_reg(REG_C4, c.c4);
        put_reg(REG_C5, c.c5);
        put_reg(REG_C6, c.c6);
        if (spare) begin
            put_reg(ADDR_SPARE_LO, 16'hFFFF);
            put_reg(ADDR_SPARE_HI, 16'(~c.c5));
        end
        cfg_we <= 1'b0;
        cal_now = c;
    endtask

    function automatic logic [15:0] pick_word(int mode, logic [15:0] typ);
        int r;
        case (mode)
            0: return 16'(int'(typ) + int'($urandom_range(0, 4000)) - 2000);
            1: return 16'($urandom);
            2: begin
                r = $urandom_range(0, 2);
                if (r == 0)
                    return 16'h0000;
                if (r == 1)
                    return 16'hFFFF;
                return 16'($urandom);
            end
            default: return typ;
        endcase
    endfunction

    // half the beats sit near the reference point so both correction branches
    // and unclamped pressures show up, the rest span the whole field
    task automatic run_random(input int count);
        int v;
        int span;
        logic [23:0] d2, d1;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 1)) begin
                span = $urandom_range(0, 1 << 21);
                v = int'(cal_now.c5) * 256 + int'($urandom_range(0, 2 * span)) - span;
                d2 = (v < 0) ? 24'd0 : (v > int'(RAW_MAX)) ? RAW_MAX : 24'(v);
            end else begin
                d2 = 24'($urandom);
            end
            if ($urandom_range(0, 1)) begin
                v = 9000000 + int'($urandom_range(0, 8000000)) - 4000000;
                d1 = 24'(v);
            end else begin
                d1 = 24'($urandom);
            end
            send_conversion(d2, d1);
        end
    endtask

    initial begin : stimulus
        bpc_calib_t c;
        int mode;
        sb = new();
        cal_now = '0;
        steady = 1'b0;
        results_seen = 0;
        cycles = 0;
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_addr <= '0;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // calibration still at its reset value of zero
        send_conversion(24'd0, 24'd0);
        send_conversion(RAW_MAX, RAW_MAX);
        send_conversion(24'd8569150, 24'd9085466);

        // typical calibration, spare indexes written with junk
        load_calib(CAL_TYPICAL, 1'b1);
        send_conversion(24'd8569150, 24'd9085466);
        send_conversion(24'd0, 24'd0);
        send_conversion(RAW_MAX, RAW_MAX);
        send_conversion(24'd0, RAW_MAX);
        send_conversion(RAW_MAX, 24'd0);
        // right at 20 C: dT of -296 still gives 2000, -297 gives 1999
        send_conversion(24'd8566488, 24'd9085466);
        send_conversion(24'd8566487, 24'd9085466);
        // around -15 C on the first-order temperature
        send_conversion(24'd7529468, 24'd8000000);
        send_conversion(24'd7529467, 24'd8000000);
        send_conversion(24'd8270484, 24'd9085466);
        send_conversion(24'd7381584, 24'd8500000);
        // too cold and too hot
        send_conversion(24'd6788984, 24'd9085466);
        send_conversion(24'd10566784, 24'd9085466);
        // pressure far below range
        send_conversion(24'd8569150, 24'd1000);

        load_calib(CAL_ONES, 1'b0);
        send_conversion(24'd0, 24'd0);
        send_conversion(RAW_MAX, RAW_MAX);
        send_conversion(24'h800000, 24'h800000);

        load_calib(CAL_ZERO, 1'b1);
        send_conversion(24'd123456, 24'd654321);

        for (int k = 0; k < RANDOM_PHASES; k++) begin
            mode = k % 4;
            c.c1 = pick_word(mode, CAL_TYPICAL.c1);
            c.c2 = pick_word(mode, CAL_TYPICAL.c2);
            c.c3 = pick_word(mode, CAL_TYPICAL.c3);
            c.c4 = pick_word(mode, CAL_TYPICAL.c4);
            c.c5 = pick_word(mode, CAL_TYPICAL.c5);
            c.c6 = pick_word(mode, CAL_TYPICAL.c6);
            load_calib(c, k == 2);
            steady = (k % 3 == 1);
            run_random(ITEMS_PER_PHASE);
        end
        steady = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
